/* hdl/rbc_pkg.sv */
// Shared types, constants and helpers for the RGB brightness/contrast block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rbc_pkg;

    localparam int CH_W       = 8;
    localparam int LANES      = 3;
    localparam int TDATA_W    = LANES * CH_W;
    localparam int BRIGHT_W   = 9;
    localparam int FACTOR_W   = 18;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 29;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int BASE_W     = 9;
    localparam int OFFSET_W   = 13;
    localparam int SUM_W      = 14;
    localparam int DIV_STEPS  = FACTOR_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [8:0]          CONTRAST_NUM = 9'd259;
    localparam logic [7:0]          CONTRAST_DEN = 8'd255;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE   = FACTOR_W'(1 << FRAC_BITS);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BASE_BRIGHT   = 2'd0,
        CFG_BASE_CONTRAST = 2'd1,
        CFG_OFF_BRIGHT    = 2'd2,
        CFG_OFF_CONTRAST  = 2'd3
    } t_cfg_addr;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN
    } t_div_state;

    typedef struct packed {
        logic                       busy;
        logic signed [BRIGHT_W-1:0] bright;
        logic [FACTOR_W-1:0]        factor;
    } t_setup;

    // Clamp an effective setting to -128..128.
    function automatic logic signed [BRIGHT_W-1:0] clamp_setting(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [BRIGHT_W-1:0] r;
        if (v < -14'sd128) begin
            r = -9'sd128;
        end else if (v > 14'sd128) begin
            r = 9'sd128;
        end else begin
            r = v[BRIGHT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/rbc_setup.sv */
// Settings registers, clamped brightness and the contrast factor divider.
// Depends on rbc_pkg.
`default_nettype none

module rbc_setup import rbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_addr             i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_setup                o_setup
);

    logic signed [BASE_W-1:0]   r_base_bright;
    logic signed [BASE_W-1:0]   r_base_contrast;
    logic signed [OFFSET_W-1:0] r_off_bright;
    logic signed [OFFSET_W-1:0] r_off_contrast;
    logic signed [BRIGHT_W-1:0] r_bright;
    logic [FACTOR_W-1:0]        r_factor;

    t_div_state                 r_state;
    t_div_state                 n_state;
    logic [DIV_CNT_W-1:0]       r_cnt;
    logic [18:0]                r_rem;
    logic [18:0]                r_div4;
    logic [FACTOR_W-1:0]        r_quot;

    logic signed [SUM_W-1:0]    w_sum_b;
    logic signed [SUM_W-1:0]    w_sum_c;
    logic signed [BRIGHT_W-1:0] w_c;
    logic signed [9:0]          w_cp;
    logic signed [9:0]          w_cm;
    logic [16:0]                w_a;
    logic [16:0]                w_den;
    logic [19:0]                w_shift;
    logic [19:0]                w_diff;
    logic                       w_ge;
    logic [FACTOR_W-1:0]        w_qnext;
    logic                       w_busy;
    logic                       w_load;
    logic                       w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_bright   <= '0;
            r_base_contrast <= '0;
            r_off_bright    <= '0;
            r_off_contrast  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BASE_BRIGHT:   r_base_bright   <= i_cfg_data[BASE_W-1:0];
                CFG_BASE_CONTRAST: r_base_contrast <= i_cfg_data[BASE_W-1:0];
                CFG_OFF_BRIGHT:    r_off_bright    <= i_cfg_data;
                CFG_OFF_CONTRAST:  r_off_contrast  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_sum_b = {{(SUM_W-BASE_W){r_base_bright[BASE_W-1]}}, r_base_bright}
                   + {r_off_bright[OFFSET_W-1], r_off_bright};
    assign w_sum_c = {{(SUM_W-BASE_W){r_base_contrast[BASE_W-1]}}, r_base_contrast}
                   + {r_off_contrast[OFFSET_W-1], r_off_contrast};
    assign w_c     = clamp_setting(w_sum_c);

    // Numerator 259*(C+255) and divisor 255*(259-C), both positive.
    assign w_cp  = {w_c[BRIGHT_W-1], w_c} + 10'sd255;
    assign w_cm  = 10'sd259 - {w_c[BRIGHT_W-1], w_c};
    assign w_a   = {8'd0, w_cp[8:0]} * {8'd0, CONTRAST_NUM};
    assign w_den = {8'd0, w_cm[8:0]} * {9'd0, CONTRAST_DEN};

    // Restoring divide against 4*den: first step yields the 2^1 bit.
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_div4};
    assign w_ge    = (w_shift >= {1'b0, r_div4});
    assign w_qnext = {r_quot[FACTOR_W-2:0], w_ge};

    always_comb begin
        n_state = r_state;
        priority if (i_cfg_we) begin
            n_state = DIV_LOAD;
        end else if (r_state == DIV_LOAD) begin
            n_state = DIV_RUN;
        end else if (r_state == DIV_RUN && r_cnt == DIV_CNT_W'(1)) begin
            n_state = DIV_IDLE;
        end
    end

    always_comb begin
        w_busy = 1'b1;
        w_load = 1'b0;
        w_step = 1'b0;
        unique case (r_state)
            DIV_IDLE: w_busy = 1'b0;
            DIV_LOAD: w_load = 1'b1;
            DIV_RUN:  w_step = 1'b1;
            default:  w_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= DIV_IDLE;
            r_cnt    <= '0;
            r_factor <= FACTOR_ONE;
            r_bright <= '0;
        end else begin
            r_state  <= n_state;
            r_bright <= clamp_setting(w_sum_b);
            if (w_load) begin
                r_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (w_step) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_factor <= w_qnext;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem  <= {2'b00, w_a};
            r_div4 <= {w_den, 2'b00};
        end else if (w_step) begin
            r_rem  <= w_ge ? w_diff[18:0] : w_shift[18:0];
            r_quot <= w_qnext;
        end
    end

    assign o_setup.busy   = w_busy;
    assign o_setup.bright = r_bright;
    assign o_setup.factor = r_factor;

`ifndef SYNTHESIS
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == DIV_LOAD))
        else $error("settings write did not restart the factor divide");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_RUN) |-> (r_rem < r_div4))
        else $error("divider remainder escaped its bound");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_RUN) |-> (r_cnt != '0))
        else $error("divider running with exhausted step count");

    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_IDLE) |->
            (r_factor >= 18'd21840 && r_factor <= 18'd194620))
        else $error("contrast factor out of range while idle");
`endif

endmodule

`default_nettype wire

/* hdl/rbc_lane.sv */
// One color channel: offset and scale multiply, then pivot and saturate.
// Depends on rbc_pkg.
`default_nettype none

module rbc_lane import rbc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_ld_px,
    input  logic                       i_ld_prod,
    input  logic                       i_ld_out,
    input  logic [CH_W-1:0]            i_px,
    input  logic signed [BRIGHT_W-1:0] i_bright,
    input  logic [FACTOR_W-1:0]        i_factor,
    output logic [CH_W-1:0]            o_px
);

    logic [CH_W-1:0]          r_px;
    logic signed [PROD_W-1:0] r_prod;
    logic [CH_W-1:0]          r_out;

    logic signed [9:0]        w_val;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [13:0]       w_q;
    logic [CH_W-1:0]          n_out;

    // x + B - 128 lies in -256..255
    assign w_val  = $signed({2'b00, r_px}) + $signed({i_bright[BRIGHT_W-1], i_bright})
                  - $signed(10'd128);
    assign w_prod = $signed({1'b0, i_factor}) * w_val;

    // Floor by arithmetic shift, then add the mid-grey pivot.
    assign w_q = $signed({r_prod[PROD_W-1], r_prod[PROD_W-1:FRAC_BITS]}) + 14'sd128;

    always_comb begin
        priority if (w_q[13]) begin
            n_out = '0;
        end else if (w_q > 14'sd255) begin
            n_out = '1;
        end else begin
            n_out = w_q[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_px) begin
            r_px <= i_px;
        end
        if (i_ld_prod) begin
            r_prod <= w_prod;
        end
        if (i_ld_out) begin
            r_out <= n_out;
        end
    end

    assign o_px = r_out;

endmodule

`default_nettype wire

/* hdl/rgb_brightness_contrast.sv */
// Top level of the RGB brightness/contrast block: stream handshake, pipeline
// control and output merge. Depends on rbc_pkg, rbc_setup and rbc_lane.
//
//   channel | dir | handshake                          | payload
//   --------+-----+------------------------------------+--------------------------
//   s_axis  | in  | i_s_axis_tvalid / o_s_axis_tready  | red, green, blue in
//   m_axis  | out | o_m_axis_tvalid / i_m_axis_tready  | red, green, blue out
//   cfg     | in  | i_cfg_we (no stall)                | i_cfg_addr, i_cfg_data
//
// One pixel per cycle while m_axis is ready and no divide runs; three lanes,
// three stages: pixel, product and output registers, the last offered on m_axis.
// Any settings write starts the contrast factor divide: a load state plus
// 18 steps, one quotient bit per cycle, during which s_axis is not ready.
// Synchronous active-low reset clears settings to zero (factor 1.0).
// A stall on m_axis backs up through the stages; each stage holds its request.
`default_nettype none

module rgb_brightness_contrast import rbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [TDATA_W-1:0]    i_s_axis_tdata,   // red_in, green_in, blue_in
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [TDATA_W-1:0]    o_m_axis_tdata,   // red_out, green_out, blue_out
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_setup          w_setup;
    logic            r_v1;
    logic            r_v2;
    logic            r_v3;
    logic            w_free1;
    logic            w_free2;
    logic            w_free3;
    logic            w_ld1;
    logic            w_ld2;
    logic            w_ld3;
    logic [CH_W-1:0] w_out [LANES];

    rbc_setup u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (t_cfg_addr'(i_cfg_addr)),
        .i_cfg_data (i_cfg_data),
        .o_setup    (w_setup)
    );

    assign w_free3 = !r_v3 || i_m_axis_tready;
    assign w_free2 = !r_v2 || w_free3;
    assign w_free1 = !r_v1 || w_free2;

    assign o_s_axis_tready = w_free1 && !w_setup.busy;
    assign w_ld1 = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ld2 = r_v1 && w_free2;
    assign w_ld3 = r_v2 && w_free3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ld1) begin
                r_v1 <= 1'b1;
            end else if (w_ld2) begin
                r_v1 <= 1'b0;
            end
            if (w_ld2) begin
                r_v2 <= 1'b1;
            end else if (w_ld3) begin
                r_v2 <= 1'b0;
            end
            if (w_ld3) begin
                r_v3 <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_v3 <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rbc_lane u_lane (
            .i_clk     (i_clk),
            .i_ld_px   (w_ld1),
            .i_ld_prod (w_ld2),
            .i_ld_out  (w_ld3),
            .i_px      (i_s_axis_tdata[g*CH_W +: CH_W]),
            .i_bright  (w_setup.bright),
            .i_factor  (w_setup.factor),
            .o_px      (w_out[g])
        );
    end

    // Merge the lane registers into one output request.
    always_comb begin
        o_m_axis_tdata = '0;
        for (int k = 0; k < LANES; k++) begin
            o_m_axis_tdata[k*CH_W +: CH_W] = w_out[k];
        end
    end

    assign o_m_axis_tvalid = r_v3;

endmodule

`default_nettype wire
